[src/bounded_list_engine_macros.svh]
// Assertion macros used by the list engine top level.
`ifndef BOUNDED_LIST_ENGINE_MACROS_SVH
`define BOUNDED_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BLE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/blist_pkg.sv]
// Types, constants and codes shared by the list engine modules.
`default_nettype none

package blist_pkg;

   // List geometry.
   localparam int DEPTH      = 16;
   localparam int ITEM_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);

   // Fixed field widths of the stream items.
   localparam int OPCODE_W   = 4;
   localparam int VALUE_W    = 32;
   localparam int POSITION_W = 4;
   localparam int READ_W     = 32;
   localparam int COUNT_W    = 5;
   localparam int STATUS_W   = 2;

   localparam int REQ_BITS = OPCODE_W + VALUE_W + POSITION_W;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS = READ_W + 1 + COUNT_W + STATUS_W;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   // Operation codes.
   typedef enum logic [OPCODE_W-1:0] {
      OP_APPEND       = 4'd0,
      OP_PREPEND      = 4'd1,
      OP_GET          = 4'd2,
      OP_FIRST        = 4'd3,
      OP_LAST         = 4'd4,
      OP_INCLUDES     = 4'd5,
      OP_REMOVE_VALUE = 4'd6,
      OP_REMOVE_AT    = 4'd7,
      OP_REMOVE_FIRST = 4'd8,
      OP_REMOVE_LAST  = 4'd9,
      OP_CLEAR        = 4'd10,
      OP_POP          = 4'd11
   } opcode_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_PASS = 2'b10
   } state_type;

   // Per-cell control: load from the shared bus, take the right or left neighbor.
   typedef struct packed {
      logic load;
      logic shl;
      logic shr;
   } cell_ctl_type;

   // Result fields, first field in the highest bits.
   typedef struct packed {
      status_type          status;
      logic [COUNT_W-1:0]  entry_count;
      logic                found;
      logic [READ_W-1:0]   read_value;
   } rsp_fields_type;

endpackage

`default_nettype wire

[src/bounded_list_engine.sv]
// Top level of the bounded list engine: controller, result register and cell row.
//
// The engine keeps an ordered list of up to DEPTH entries in a row of cells and runs one
// operation per request item: append, prepend, get, first, last, includes, remove by value,
// remove at, remove first, remove last, clear and pop. Each item yields exactly one response
// item carrying the read value, a found flag, the count after the operation and a status.
// Most operations are decoded in the accept cycle and their response is registered at that
// edge. Includes and remove by value run the accept cycle, then a pass that rotates the
// list once through the head cell, whose entry feeds the only value comparator, then a
// final step that registers the response. No new item is accepted during that pass. A
// request is taken whenever the controller is idle and the response register is empty or
// being drained in the same cycle, so a stalled response also holds off the next request.
// There is no clearing pass after reset; the count alone marks which cells hold entries.
`default_nettype none

`include "bounded_list_engine_macros.svh"

module bounded_list_engine (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_tvalid,
   output logic                          req_tready,
   // opcode [3:0], value [35:4], position [39:36]
   input  wire  [blist_pkg::REQ_W-1:0]   req_tdata,
   output logic                          rsp_tvalid,
   input  wire                           rsp_tready,
   // read_value [31:0], found [32], entry_count [37:33], status [39:38]
   output logic [blist_pkg::RSP_W-1:0]   rsp_tdata
);

   localparam int IW = blist_pkg::ITEM_WIDTH;
   localparam int CW = blist_pkg::CNT_W;
   localparam int XW = blist_pkg::IDX_W;

   // Request fields.
   blist_pkg::opcode_type                  req_opcode;
   logic [blist_pkg::VALUE_W-1:0]          req_value;
   logic [blist_pkg::POSITION_W-1:0]       req_position;
   logic [IW-1:0]                          req_item;

   assign req_opcode   = blist_pkg::opcode_type'(req_tdata[blist_pkg::OPCODE_W-1:0]);
   assign req_value    = req_tdata[blist_pkg::OPCODE_W +: blist_pkg::VALUE_W];
   assign req_position = req_tdata[blist_pkg::OPCODE_W + blist_pkg::VALUE_W +:
                                   blist_pkg::POSITION_W];
   assign req_item     = IW'(req_value);

   // Control and pass registers.
   blist_pkg::state_type   state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          remain_ff, remain_in;
   logic [IW-1:0]          key_ff, key_in;
   logic                   drop_ff, drop_in;
   logic                   found_ff, found_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   blist_pkg::rsp_fields_type rsp_ff, rsp_in;

   // Cell row interface.
   blist_pkg::cell_ctl_type [blist_pkg::DEPTH-1:0] cell_ctl;
   logic [IW-1:0]          load_data;
   logic [XW-1:0]          rd_addr;
   logic [IW-1:0]          head;
   logic [IW-1:0]          rd_data;

   // Per-item decode.
   logic                   req_fire;
   logic                   slot_free;
   logic                   list_full;
   logic                   list_empty;
   logic                   pos_bad;
   logic                   key_match;
   logic                   emit;
   logic [IW-1:0]          res_read;
   logic                   res_found;
   blist_pkg::status_type  res_status;

   // Terms used by the design checks.
   logic                   in_idle;
   logic                   in_pass;
   logic                   quick_op;
   logic                   count_in_range;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == blist_pkg::ST_IDLE) && slot_free;
   assign req_fire   = req_tvalid && req_tready;
   assign list_full  = (count_ff == CW'(blist_pkg::DEPTH));
   assign list_empty = (count_ff == '0);
   assign pos_bad    = (32'(req_position) >= 32'(count_ff));
   assign key_match  = (head == key_ff);

   assign in_idle        = (state_ff == blist_pkg::ST_IDLE);
   assign in_pass        = (state_ff == blist_pkg::ST_PASS);
   assign quick_op       = req_fire && (req_opcode != blist_pkg::OP_INCLUDES) &&
                           (req_opcode != blist_pkg::OP_REMOVE_VALUE);
   assign count_in_range = (count_ff <= CW'(blist_pkg::DEPTH));

   // Operation decode and the rotation pass for includes and remove by value.
   always_comb begin
      for (int i = 0; i < blist_pkg::DEPTH; i++) begin
         cell_ctl[i] = '0;
      end
      load_data  = req_item;
      rd_addr    = XW'(count_ff - CW'(1));
      state_in   = state_ff;
      count_in   = count_ff;
      remain_in  = remain_ff;
      key_in     = key_ff;
      drop_in    = drop_ff;
      found_in   = found_ff;
      emit       = 1'b0;
      res_read   = '0;
      res_found  = 1'b0;
      res_status = blist_pkg::STATUS_OK;

      unique case (state_ff)
         blist_pkg::ST_IDLE: begin
            if (req_fire) begin
               emit = 1'b1;
               unique case (req_opcode)
                  blist_pkg::OP_APPEND: begin
                     if (list_full) begin
                        res_status = blist_pkg::STATUS_FULL;
                     end else begin
                        cell_ctl[XW'(count_ff)].load = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  blist_pkg::OP_PREPEND: begin
                     if (list_full) begin
                        res_status = blist_pkg::STATUS_FULL;
                     end else begin
                        for (int i = 0; i < blist_pkg::DEPTH; i++) begin
                           cell_ctl[i].shr = 1'b1;
                        end
                        cell_ctl[0].load = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  blist_pkg::OP_GET: begin
                     rd_addr = XW'(req_position);
                     if (pos_bad) begin
                        res_status = blist_pkg::STATUS_RANGE;
                     end else begin
                        res_read = rd_data;
                     end
                  end
                  blist_pkg::OP_FIRST: begin
                     rd_addr = '0;
                     if (list_empty) begin
                        res_status = blist_pkg::STATUS_RANGE;
                     end else begin
                        res_read = rd_data;
                     end
                  end
                  blist_pkg::OP_LAST: begin
                     if (list_empty) begin
                        res_status = blist_pkg::STATUS_RANGE;
                     end else begin
                        res_read = rd_data;
                     end
                  end
                  blist_pkg::OP_INCLUDES, blist_pkg::OP_REMOVE_VALUE: begin
                     emit      = 1'b0;
                     state_in  = blist_pkg::ST_PASS;
                     remain_in = count_ff;
                     key_in    = req_item;
                     drop_in   = (req_opcode == blist_pkg::OP_REMOVE_VALUE);
                     found_in  = 1'b0;
                  end
                  blist_pkg::OP_REMOVE_AT: begin
                     if (pos_bad) begin
                        res_status = blist_pkg::STATUS_RANGE;
                     end else begin
                        for (int i = 0; i < blist_pkg::DEPTH; i++) begin
                           cell_ctl[i].shl = (32'(i) >= 32'(req_position));
                        end
                        count_in = count_ff - CW'(1);
                     end
                  end
                  blist_pkg::OP_REMOVE_FIRST: begin
                     if (list_empty) begin
                        res_status = blist_pkg::STATUS_RANGE;
                     end else begin
                        for (int i = 0; i < blist_pkg::DEPTH; i++) begin
                           cell_ctl[i].shl = 1'b1;
                        end
                        count_in = count_ff - CW'(1);
                     end
                  end
                  blist_pkg::OP_REMOVE_LAST: begin
                     if (list_empty) begin
                        res_status = blist_pkg::STATUS_RANGE;
                     end else begin
                        count_in = count_ff - CW'(1);
                     end
                  end
                  blist_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  blist_pkg::OP_POP: begin
                     if (list_empty) begin
                        res_status = blist_pkg::STATUS_RANGE;
                     end else begin
                        res_read = rd_data;
                        count_in = count_ff - CW'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         blist_pkg::ST_PASS: begin
            if (remain_ff != '0) begin
               // Take the head out, shift the row left and put the head back at the tail
               // unless it is being dropped.
               remain_in = remain_ff - CW'(1);
               found_in  = found_ff || key_match;
               load_data = head;
               for (int i = 0; i < blist_pkg::DEPTH; i++) begin
                  cell_ctl[i].shl = 1'b1;
               end
               if (drop_ff && key_match) begin
                  count_in = count_ff - CW'(1);
               end else begin
                  cell_ctl[XW'(count_ff - CW'(1))].load = 1'b1;
               end
            end else if (slot_free) begin
               emit      = 1'b1;
               res_found = found_ff;
               state_in  = blist_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = blist_pkg::ST_IDLE;
         end
      endcase
   end

   // Response register.
   always_comb begin
      rsp_in = rsp_ff;
      if (emit) begin
         rsp_in.read_value  = blist_pkg::READ_W'(res_read);
         rsp_in.found       = res_found;
         rsp_in.entry_count = blist_pkg::COUNT_W'(count_in);
         rsp_in.status      = res_status;
      end
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_tready);
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= blist_pkg::ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      drop_ff  <= drop_in;
      found_ff <= found_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = blist_pkg::RSP_W'(rsp_ff);

   blist_chain u_chain (
      .clock     (clock),
      .cell_ctl  (cell_ctl),
      .load_data (load_data),
      .rd_addr   (rd_addr),
      .head      (head),
      .rd_data   (rd_data)
   );

   // Design checks.
   `BLE_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_in_range, "count above depth")
   `BLE_ASSERT_NOW(a_pass_remain, clock, reset, in_pass, remain_ff <= count_ff, "pass overrun")
   `BLE_ASSERT_NEXT(a_quick_result, clock, reset, quick_op, rsp_valid_ff, "missing quick result")
   `BLE_ASSERT_NOW(a_ready_idle, clock, reset, req_tready, in_idle && slot_free, "ready when busy")

endmodule

`default_nettype wire

[src/blist_cell.sv]
// One list cell: holds a single entry and moves it to or from its neighbors.
`default_nettype none

module blist_cell (
   input  wire                                  clock,
   input  blist_pkg::cell_ctl_type              ctl,
   input  wire  [blist_pkg::ITEM_WIDTH-1:0]     load_data,
   input  wire  [blist_pkg::ITEM_WIDTH-1:0]     left_data,
   input  wire  [blist_pkg::ITEM_WIDTH-1:0]     right_data,
   output logic [blist_pkg::ITEM_WIDTH-1:0]     entry
);

   logic [blist_pkg::ITEM_WIDTH-1:0] entry_ff;
   logic [blist_pkg::ITEM_WIDTH-1:0] entry_in;

   // A load wins over a shift; otherwise the entry holds.
   always_comb begin
      entry_in = entry_ff;
      if (ctl.load) begin
         entry_in = load_data;
      end else if (ctl.shl) begin
         entry_in = right_data;
      end else if (ctl.shr) begin
         entry_in = left_data;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

[src/blist_chain.sv]
// Row of list cells with neighbor links, the head tap and one read port.
`default_nettype none

module blist_chain (
   input  wire                                          clock,
   input  blist_pkg::cell_ctl_type [blist_pkg::DEPTH-1:0] cell_ctl,
   input  wire  [blist_pkg::ITEM_WIDTH-1:0]             load_data,
   input  wire  [blist_pkg::IDX_W-1:0]                  rd_addr,
   output logic [blist_pkg::ITEM_WIDTH-1:0]             head,
   output logic [blist_pkg::ITEM_WIDTH-1:0]             rd_data
);

   logic [blist_pkg::ITEM_WIDTH-1:0] entry      [blist_pkg::DEPTH];
   logic [blist_pkg::ITEM_WIDTH-1:0] left_link  [blist_pkg::DEPTH];
   logic [blist_pkg::ITEM_WIDTH-1:0] right_link [blist_pkg::DEPTH];

   // Each cell sees its left and right neighbor; the row ends feed back on the bus or itself.
   for (genvar i = 0; i < blist_pkg::DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_link[i] = load_data;
      end else begin : g_inner_left
         assign left_link[i] = entry[i-1];
      end
      if (i == blist_pkg::DEPTH - 1) begin : g_last
         assign right_link[i] = entry[i];
      end else begin : g_inner_right
         assign right_link[i] = entry[i+1];
      end

      blist_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[i]),
         .load_data  (load_data),
         .left_data  (left_link[i]),
         .right_data (right_link[i]),
         .entry      (entry[i])
      );
   end

   assign head    = entry[0];
   assign rd_data = entry[rd_addr];

endmodule

`default_nettype wire
